[hdl/polygon_and_vertex_normals_top_assert.svh]
// assertion macros for the polygon and vertex normals block
`ifndef POLYGON_AND_VERTEX_NORMALS_TOP_ASSERT_SVH
`define POLYGON_AND_VERTEX_NORMALS_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define PVN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define PVN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/pvn_pkg.sv]
package pvn_pkg;

	// sizes of the vertex store and the corner list
	localparam int VERTEX_COUNT = 1024;
	localparam int MAX_CORNERS  = 16;

	localparam int VIDX_W  = 10;
	localparam int COORD_W = 16;
	localparam int NORM_W  = 16;
	localparam int VA_W    = $clog2(VERTEX_COUNT);
	localparam int LIST_W  = $clog2(MAX_CORNERS);
	localparam int CNT_W   = $clog2(MAX_CORNERS + 2);

	// newell sums and vertex accumulators
	localparam int SUM_W     = 63;
	localparam int ACC_W     = 24;
	localparam int ACC_RAM_W = 3 * ACC_W;
	localparam logic signed [63:0] SUM_LIMIT = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [ACC_W:0] ACC_LIMIT = (ACC_W + 1)'(8388607);

	// command codes
	localparam logic [1:0] CMD_CORNER = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NORM_W-1:0] norm_t;

endpackage

[hdl/pvn_ram.sv]
module pvn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/polygon_and_vertex_normals_top.sv]
// corner without a triple: stored directly; corner with a newell triple: six products (one shared multiplier)
// polygon end: 2 closing triples, then the shift, square, root and divide steps, and unless degenerate
//   or overflowed, an accumulator read-modify-write per stored in-range corner on the vertex ram port
// vertex read: the same shift, square, root and divide steps on the row; a zero row returns as degenerate
// clear: sweeps all 1024 ram rows, one row per cycle; the same sweep runs after reset, in_ready stays low
// arst_n clears control state, polygon state and the negate register
module polygon_and_vertex_normals_top
	import pvn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [VIDX_W-1:0] vertex_index,
	input  coord_t            coord_x,
	input  coord_t            coord_y,
	input  coord_t            coord_z,
	input  logic              last_corner,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              result_kind,
	output norm_t             normal_x,
	output norm_t             normal_y,
	output norm_t             normal_z,
	output logic              degenerate,
	output logic              corner_overflow
);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_TRI, ST_FIN, ST_PSUM, ST_VRD, ST_SHIFT, ST_SQ,
		ST_SQRT, ST_DIV, ST_EMIT, ST_ACC_RD, ST_ACC_WR, ST_DONE
	} state_t;

	state_t                   state_q;
	logic                     negate_q;
	coord_t                   first_q [3];
	coord_t                   second_q [3];
	coord_t                   older_q [3];
	coord_t                   newer_q [3];
	coord_t                   ta_q [3];
	coord_t                   tb_q [3];
	coord_t                   tc_q [3];
	logic signed [SUM_W-1:0]  sum_q [3];
	logic [CNT_W-1:0]         cnt_q;
	logic [VIDX_W-1:0]        list_q [MAX_CORNERS];
	logic                     last_q;
	logic [1:0]               phase_q;
	logic [2:0]               step_q;
	logic signed [63:0]       tmp_q;
	logic signed [63:0]       prod_s1;
	logic [62:0]              mag_q [3];
	logic                     neg_q [3];
	logic [61:0]              sq_q;
	logic [61:0]              sqr_q;
	logic [62:0]              root_q;
	logic [62:0]              bit_q;
	logic [30:0]              len_q;
	logic [45:0]              rem_q;
	logic [45:0]              dvs_q;
	logic [14:0]              quot_q;
	logic [3:0]               dstep_q;
	logic [1:0]               comp_q;
	norm_t                    n_q [3];
	logic                     degen_q;
	logic                     kind_q;
	logic [CNT_W-1:0]         k_q;
	logic [VA_W-1:0]          acc_addr_q;
	logic [VA_W-1:0]          clr_q;
	logic                     vrange_q;
	logic                     out_valid_q;
	logic                     kind_out_q;
	norm_t                    nx_q, ny_q, nz_q;
	logic                     degen_out_q;
	logic                     ovf_out_q;

	logic signed [16:0]       bd [3];
	logic signed [16:0]       cd [3];
	logic signed [31:0]       mul_a, mul_b;
	logic [62:0]              m_max;
	logic [62:0]              trial;
	logic                     sq_ge;
	logic                     div_ge;
	logic                     ovf;
	logic [VIDX_W-1:0]        list_rd;
	logic                     ram_we;
	logic [VA_W-1:0]          ram_waddr;
	logic [ACC_RAM_W-1:0]     ram_wdata;
	logic [VA_W-1:0]          ram_raddr;
	logic [ACC_RAM_W-1:0]     ram_rdata;
	logic signed [ACC_W-1:0]  rdv [3];
	logic signed [ACC_W-1:0]  accn [3];

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (v > SUM_LIMIT) r = SUM_LIMIT;
		if (v < -SUM_LIMIT) r = -SUM_LIMIT;
		return r[SUM_W-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
		logic signed [ACC_W:0] r;
		r = v;
		if (v > ACC_LIMIT) r = ACC_LIMIT;
		if (v < -ACC_LIMIT) r = -ACC_LIMIT;
		return r[ACC_W-1:0];
	endfunction

	function automatic logic [62:0] abs63(input logic signed [62:0] v);
		return v[62] ? 63'(-v) : 63'(v);
	endfunction

	function automatic logic in_range(input logic [VIDX_W-1:0] v);
		return int'(v) < VERTEX_COUNT;
	endfunction

	// first divide remainder: mag * 16384 + len / 2
	function automatic logic [45:0] div_init(input logic [62:0] m, input logic [30:0] l);
		return {2'b00, m[29:0], 14'b0} + 46'(l >> 1);
	endfunction

	// edge vectors of the current triple
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bd[i] = 17'(tb_q[i]) - 17'(ta_q[i]);
			cd[i] = 17'(tc_q[i]) - 17'(ta_q[i]);
		end
	end

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_TRI) begin
			case (step_q)
				3'd0: begin mul_a = 32'(bd[1]); mul_b = 32'(cd[2]); end
				3'd1: begin mul_a = 32'(bd[2]); mul_b = 32'(cd[1]); end
				3'd2: begin mul_a = 32'(bd[2]); mul_b = 32'(cd[0]); end
				3'd3: begin mul_a = 32'(bd[0]); mul_b = 32'(cd[2]); end
				3'd4: begin mul_a = 32'(bd[0]); mul_b = 32'(cd[1]); end
				3'd5: begin mul_a = 32'(bd[1]); mul_b = 32'(cd[0]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else if (state_q == ST_SQ && step_q < 3'd3) begin
			mul_a = {2'b00, mag_q[step_q[1:0]][29:0]};
			mul_b = {2'b00, mag_q[step_q[1:0]][29:0]};
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// largest magnitude, root trial and divide compare
	always_comb begin
		m_max = mag_q[0];
		if (mag_q[1] > m_max) m_max = mag_q[1];
		if (mag_q[2] > m_max) m_max = mag_q[2];
		trial  = root_q + bit_q;
		sq_ge  = {1'b0, sqr_q} >= trial;
		div_ge = rem_q >= dvs_q;
	end

	assign ovf     = cnt_q > CNT_W'(MAX_CORNERS);
	assign list_rd = list_q[k_q[LIST_W-1:0]];

	// accumulator update from the ram row
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rdv[i]  = ram_rdata[i*ACC_W +: ACC_W];
			accn[i] = sat_acc((ACC_W + 1)'(rdv[i]) + (ACC_W + 1)'(n_q[i]));
		end
	end

	// vertex ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = acc_addr_q;
		ram_wdata = {accn[2], accn[1], accn[0]};
		ram_raddr = VA_W'(list_rd);
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_ACC_WR) begin
			ram_we = 1'b1;
		end
		if (state_q == ST_IDLE) begin
			ram_raddr = VA_W'(vertex_index);
		end
	end

	pvn_ram #(
		.WIDTH(ACC_RAM_W),
		.DEPTH(VERTEX_COUNT)
	) u_acc_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// negate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			negate_q <= 1'b0;
		end else if (cfg_we) begin
			negate_q <= cfg_wdata;
		end
	end

	// corner list, written as corners arrive
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && cmd == CMD_CORNER
				&& cnt_q < CNT_W'(MAX_CORNERS)) begin
			list_q[cnt_q[LIST_W-1:0]] <= vertex_index;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			kind_q      <= 1'b0;
			degen_q     <= 1'b0;
			vrange_q    <= 1'b0;
			phase_q     <= '0;
			step_q      <= '0;
			k_q         <= '0;
			dstep_q     <= '0;
			comp_q      <= '0;
			for (int i = 0; i < 3; i++) begin
				first_q[i]  <= '0;
				second_q[i] <= '0;
				older_q[i]  <= '0;
				newer_q[i]  <= '0;
				sum_q[i]    <= '0;
			end
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				// zero sweep of the accumulators
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == VA_W'(VERTEX_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end

				// take a transaction
				ST_IDLE: begin
					if (in_valid) begin
						case (cmd)
							CMD_CORNER: begin
								kind_q  <= 1'b0;
								last_q  <= last_corner;
								if (cnt_q == '0) first_q <= '{coord_x, coord_y, coord_z};
								else if (cnt_q == CNT_W'(1))
									second_q <= '{coord_x, coord_y, coord_z};
								older_q <= newer_q;
								newer_q <= '{coord_x, coord_y, coord_z};
								if (cnt_q <= CNT_W'(MAX_CORNERS)) cnt_q <= cnt_q + 1'b1;
								if (cnt_q >= CNT_W'(2)) begin
									ta_q    <= older_q;
									tb_q    <= newer_q;
									tc_q    <= '{coord_x, coord_y, coord_z};
									phase_q <= 2'd0;
									step_q  <= '0;
									state_q <= ST_TRI;
								end else if (last_corner) begin
									state_q <= ST_FIN;
								end
							end
							CMD_READ: begin
								kind_q   <= 1'b1;
								vrange_q <= in_range(vertex_index);
								state_q  <= ST_VRD;
							end
							CMD_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end

				// one newell triple, six products on the shared multiplier
				ST_TRI: begin
					step_q <= step_q + 1'b1;
					if (step_q != '0) begin
						if (step_q[0]) begin
							tmp_q <= prod_s1;
						end else begin
							sum_q[2'(step_q[2:1] - 2'd1)] <= sat_sum(
								64'(sum_q[2'(step_q[2:1] - 2'd1)]) + tmp_q - prod_s1);
						end
					end
					if (step_q == 3'd6) begin
						step_q <= '0;
						case (phase_q)
							2'd0: state_q <= last_q ? ST_FIN : ST_IDLE;
							2'd1: begin
								ta_q    <= newer_q;
								tb_q    <= first_q;
								tc_q    <= second_q;
								phase_q <= 2'd2;
							end
							default: state_q <= ST_PSUM;
						endcase
					end
				end

				// polygon end: closing triples or a short polygon
				ST_FIN: begin
					if (cnt_q >= CNT_W'(3)) begin
						ta_q    <= older_q;
						tb_q    <= newer_q;
						tc_q    <= first_q;
						phase_q <= 2'd1;
						step_q  <= '0;
						state_q <= ST_TRI;
					end else begin
						degen_q <= 1'b1;
						n_q     <= '{default: '0};
						state_q <= ST_EMIT;
					end
				end

				// magnitudes of the newell sum
				ST_PSUM: begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= abs63(sum_q[i]);
						neg_q[i] <= sum_q[i][SUM_W-1];
					end
					state_q <= ST_SHIFT;
				end

				// magnitudes of an accumulator row
				ST_VRD: begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= vrange_q ? abs63(63'(rdv[i])) : '0;
						neg_q[i] <= vrange_q & rdv[i][ACC_W-1];
					end
					state_q <= ST_SHIFT;
				end

				// bring the largest magnitude into [2^29, 2^30)
				ST_SHIFT: begin
					if (m_max == '0) begin
						degen_q <= 1'b1;
						n_q     <= '{default: '0};
						state_q <= ST_EMIT;
					end else if (m_max[62:30] != '0) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
					end else if (!m_max[29]) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
					end else begin
						sq_q    <= '0;
						step_q  <= '0;
						state_q <= ST_SQ;
					end
				end

				// sum of squares
				ST_SQ: begin
					step_q <= step_q + 1'b1;
					if (step_q != '0) begin
						sq_q <= sq_q + prod_s1[61:0];
					end
					if (step_q == 3'd3) begin
						sqr_q   <= sq_q + prod_s1[61:0];
						root_q  <= '0;
						bit_q   <= 63'(1) << 62;
						state_q <= ST_SQRT;
					end
				end

				// integer square root, one result bit per cycle
				ST_SQRT: begin
					if (bit_q != '0) begin
						if (sq_ge) begin
							sqr_q  <= 62'({1'b0, sqr_q} - trial);
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end else begin
						len_q   <= root_q[30:0];
						rem_q   <= div_init(mag_q[0], root_q[30:0]);
						dvs_q   <= {1'b0, root_q[30:0], 14'b0};
						quot_q  <= '0;
						dstep_q <= '0;
						comp_q  <= '0;
						state_q <= ST_DIV;
					end
				end

				// restoring divide, one quotient bit per cycle, three components
				ST_DIV: begin
					if (div_ge) rem_q <= rem_q - dvs_q;
					quot_q  <= {quot_q[13:0], div_ge};
					dvs_q   <= dvs_q >> 1;
					dstep_q <= dstep_q + 1'b1;
					if (dstep_q == 4'd14) begin
						n_q[comp_q] <= neg_q[comp_q] ? -norm_t'({quot_q[13:0], div_ge})
							: norm_t'({quot_q[13:0], div_ge});
						dstep_q <= '0;
						quot_q  <= '0;
						if (comp_q == 2'd2) begin
							degen_q <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							comp_q <= comp_q + 1'b1;
							rem_q  <= div_init(mag_q[comp_q + 1'b1], len_q);
							dvs_q  <= {1'b0, len_q, 14'b0};
						end
					end
				end

				// load the output register once it is free
				ST_EMIT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						kind_out_q  <= kind_q;
						nx_q        <= negate_q ? -n_q[0] : n_q[0];
						ny_q        <= negate_q ? -n_q[1] : n_q[1];
						nz_q        <= negate_q ? -n_q[2] : n_q[2];
						degen_out_q <= degen_q;
						ovf_out_q   <= !kind_q && ovf;
						k_q         <= '0;
						state_q     <= (!kind_q && !degen_q && !ovf) ? ST_ACC_RD : ST_DONE;
					end
				end

				// walk the corner list
				ST_ACC_RD: begin
					if (k_q >= cnt_q) begin
						state_q <= ST_DONE;
					end else if (in_range(list_rd)) begin
						acc_addr_q <= VA_W'(list_rd);
						state_q    <= ST_ACC_WR;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end

				ST_ACC_WR: begin
					k_q     <= k_q + 1'b1;
					state_q <= ST_ACC_RD;
				end

				// polygon state back to empty after a polygon result
				ST_DONE: begin
					if (!kind_q) begin
						cnt_q <= '0;
						for (int i = 0; i < 3; i++) begin
							first_q[i]  <= '0;
							second_q[i] <= '0;
							older_q[i]  <= '0;
							newer_q[i]  <= '0;
							sum_q[i]    <= '0;
						end
					end
					state_q <= ST_IDLE;
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready        = state_q == ST_IDLE;
	assign out_valid       = out_valid_q;
	assign result_kind     = kind_out_q;
	assign normal_x        = nx_q;
	assign normal_y        = ny_q;
	assign normal_z        = nz_q;
	assign degenerate      = degen_out_q;
	assign corner_overflow = ovf_out_q;

endmodule

[hdl/pvn_checker.sv]
`include "polygon_and_vertex_normals_top_assert.svh"

module pvn_checker
	import pvn_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_we,
	input logic              cfg_wdata,
	input logic              in_valid,
	input logic              in_ready,
	input logic [1:0]        cmd,
	input logic [VIDX_W-1:0] vertex_index,
	input coord_t            coord_x,
	input coord_t            coord_y,
	input coord_t            coord_z,
	input logic              last_corner,
	input logic              out_valid,
	input logic              out_ready,
	input logic              result_kind,
	input norm_t             normal_x,
	input norm_t             normal_y,
	input norm_t             normal_z,
	input logic              degenerate,
	input logic              corner_overflow
);

	// a waiting result holds
	`PVN_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(normal_x) && $stable(result_kind), "output changed while stalled")

	// degenerate results carry a zero normal
	`PVN_ASSERT_IMP(a_degen_zero, out_valid && degenerate,
		normal_x == '0 && normal_y == '0 && normal_z == '0, "degenerate result not zero")

	// overflow only on polygon results
	`PVN_ASSERT_IMP(a_ovf_kind, out_valid && corner_overflow,
		result_kind == 1'b0, "overflow flag on a vertex result")

	// a clear transaction starts the sweep
	`PVN_ASSERT_NXT(a_clear_busy, in_valid && in_ready && cmd == CMD_CLEAR,
		!in_ready, "ready during clear sweep")

endmodule

bind polygon_and_vertex_normals_top pvn_checker u_pvn_checker (.*);

[tb/tb_polygon_and_vertex_normals_top.sv]
module tb_polygon_and_vertex_normals_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pvn_pkg::*;

	localparam longint NEWELL_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam int VACC_MAX = 8388607;
	localparam int SETTLE_CYCLES = 1200;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam bit KIND_POLYGON = 1'b0;
	localparam bit KIND_VERTEX = 1'b1;

	typedef struct {
		bit kind;
		norm_t nx;
		norm_t ny;
		norm_t nz;
		bit degen;
		bit ovf;
	} normal_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = CMD_CORNER;
	logic [VIDX_W-1:0] vertex_index = '0;
	coord_t coord_x = '0;
	coord_t coord_y = '0;
	coord_t coord_z = '0;
	logic last_corner = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic result_kind;
	norm_t normal_x;
	norm_t normal_y;
	norm_t normal_z;
	logic degenerate;
	logic corner_overflow;

	// shadow state of the block
	bit negate_flag;
	longint first_pt[3], second_pt[3], older_pt[3], newer_pt[3];
	longint newell_acc[3];
	int corner_cnt;
	int corner_vidx[MAX_CORNERS];
	int vert_acc[VERTEX_COUNT][3];

	normal_result_t pending_normals[$];
	int failures = 0;
	bit no_idle = 1'b0;
	int n_polygons = 0, n_reads = 0, n_clears = 0, n_checked = 0;

	polygon_and_vertex_normals_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.vertex_index(vertex_index),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.last_corner(last_corner),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.degenerate(degenerate),
		.corner_overflow(corner_overflow)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// newell cross product of one triple, saturating sums
	function automatic void add_newell(input longint a[3], input longint b[3],
			input longint c[3]);
		longint d1[3], d2[3], t[3], s;
		for (int i = 0; i < 3; i++) begin
			d1[i] = b[i] - a[i];
			d2[i] = c[i] - a[i];
		end
		t[0] = d1[1] * d2[2] - d1[2] * d2[1];
		t[1] = d1[2] * d2[0] - d1[0] * d2[2];
		t[2] = d1[0] * d2[1] - d1[1] * d2[0];
		for (int i = 0; i < 3; i++) begin
			s = newell_acc[i] + t[i];
			if (s > NEWELL_MAX)
				s = NEWELL_MAX;
			if (s < -NEWELL_MAX)
				s = -NEWELL_MAX;
			newell_acc[i] = s;
		end
	endfunction

	// unit vector in Q1.14, returns 1 for a zero vector
	function automatic bit unit_vector(input longint v[3], output int q[3]);
		longint unsigned mag[3], m, s, len, b;
		bit neg[3];
		for (int i = 0; i < 3; i++) begin
			neg[i] = v[i] < 0;
			mag[i] = neg[i] ? -v[i] : v[i];
			q[i] = 0;
		end
		m = mag[0];
		if (mag[1] > m)
			m = mag[1];
		if (mag[2] > m)
			m = mag[2];
		if (m == 0)
			return 1'b1;
		while (m >= (64'd1 << 30)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++)
				mag[i] >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++)
				mag[i] <<= 1;
		end
		s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		// integer square root, bit by bit
		len = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= len + b) begin
				s -= len + b;
				len = (len >> 1) + b;
			end else begin
				len >>= 1;
			end
			b >>= 2;
		end
		for (int i = 0; i < 3; i++) begin
			q[i] = int'((mag[i] * 64'd16384 + len / 2) / len);
			if (neg[i])
				q[i] = -q[i];
		end
		return 1'b0;
	endfunction

	function automatic void push_normal(bit kind, int q[3], bit degen, bit ovf);
		normal_result_t r;
		r.kind = kind;
		r.nx = norm_t'(negate_flag ? -q[0] : q[0]);
		r.ny = norm_t'(negate_flag ? -q[1] : q[1]);
		r.nz = norm_t'(negate_flag ? -q[2] : q[2]);
		r.degen = degen;
		r.ovf = ovf;
		pending_normals.push_back(r);
	endfunction

	// expected outcome of one accepted transaction
	function automatic void predict_normals(logic [1:0] op, int vi, longint p[3],
			bit last);
		int q[3];
		longint acc[3];
		bit degen, ovf;
		int s;
		case (op)
			CMD_CLEAR: begin
				foreach (vert_acc[k, i])
					vert_acc[k][i] = 0;
			end
			CMD_READ: begin
				for (int i = 0; i < 3; i++)
					acc[i] = (vi < VERTEX_COUNT) ? longint'(vert_acc[vi][i]) : 0;
				degen = unit_vector(acc, q);
				push_normal(KIND_VERTEX, q, degen, 1'b0);
			end
			CMD_CORNER: begin
				if (corner_cnt == 0)
					first_pt = p;
				else if (corner_cnt == 1)
					second_pt = p;
				else
					add_newell(older_pt, newer_pt, p);
				older_pt = newer_pt;
				newer_pt = p;
				if (corner_cnt < MAX_CORNERS)
					corner_vidx[corner_cnt] = vi;
				if (corner_cnt <= MAX_CORNERS)
					corner_cnt++;
				if (last) begin
					q = '{0, 0, 0};
					degen = 1'b1;
					ovf = corner_cnt > MAX_CORNERS;
					if (corner_cnt >= 3) begin
						add_newell(older_pt, newer_pt, first_pt);
						add_newell(newer_pt, first_pt, second_pt);
						degen = unit_vector(newell_acc, q);
					end
					// spread the normal onto each corner's vertex
					if (!degen && !ovf)
						for (int k = 0; k < corner_cnt && k < MAX_CORNERS; k++)
							if (corner_vidx[k] < VERTEX_COUNT)
								for (int i = 0; i < 3; i++) begin
									s = vert_acc[corner_vidx[k]][i] + q[i];
									if (s > VACC_MAX)
										s = VACC_MAX;
									if (s < -VACC_MAX)
										s = -VACC_MAX;
									vert_acc[corner_vidx[k]][i] = s;
								end
					push_normal(KIND_POLYGON, q, degen, ovf);
					for (int i = 0; i < 3; i++) begin
						first_pt[i] = 0;
						second_pt[i] = 0;
						older_pt[i] = 0;
						newer_pt[i] = 0;
						newell_acc[i] = 0;
					end
					corner_cnt = 0;
				end
			end
			default: ;
		endcase
	endfunction

	// one input transaction, with a random gap in front
	task automatic send_item(logic [1:0] op, int vi, int x, int y, int z, bit last);
		int gap;
		longint p[3];
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		vertex_index <= vi[VIDX_W-1:0];
		coord_x <= coord_t'(x);
		coord_y <= coord_t'(y);
		coord_z <= coord_t'(z);
		last_corner <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		p[0] = longint'(coord_t'(x));
		p[1] = longint'(coord_t'(y));
		p[2] = longint'(coord_t'(z));
		if (op == CMD_READ)
			n_reads++;
		if (op == CMD_CLEAR)
			n_clears++;
		if (op == CMD_CORNER && last)
			n_polygons++;
		predict_normals(op, vi, p, last);
	endtask

	// wait for every result and let any clear sweep finish before the register is written
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (pending_normals.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_negate(bit v);
		drain_and_settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		negate_flag = v;
	endtask

	task automatic send_triangle(int v0, int v1, int v2, int c[9]);
		send_item(CMD_CORNER, v0, c[0], c[1], c[2], 1'b0);
		send_item(CMD_CORNER, v1, c[3], c[4], c[5], 1'b0);
		send_item(CMD_CORNER, v2, c[6], c[7], c[8], 1'b1);
	endtask

	task automatic test_unwritten_reads();
		send_item(CMD_READ, 0, 0, 0, 0, 1'b0);
		send_item(CMD_READ, 1023, -1, -1, -1, 1'b1);
	endtask

	task automatic test_short_polygons();
		send_item(CMD_CORNER, 5, 100, 200, 300, 1'b1);
		send_item(CMD_CORNER, 6, -32768, 32767, 0, 1'b0);
		send_item(CMD_CORNER, 7, 32767, -32768, 1, 1'b1);
	endtask

	task automatic test_extreme_triangle();
		send_triangle(0, 1023, 512,
			'{-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767});
		send_item(CMD_READ, 1023, 0, 0, 0, 1'b0);
	endtask

	task automatic test_flat_polygon();
		// collinear corners give a zero sum
		send_triangle(1, 2, 3, '{0, 0, 0, 10, 10, 10, 20, 20, 20});
		send_item(CMD_READ, 1, 0, 0, 0, 1'b0);
	endtask

	task automatic test_unused_and_clear();
		send_item(CMD_UNUSED, 1023, 32767, -32768, 1, 1'b1);
		send_item(CMD_CORNER, 9, 0, 0, 0, 1'b0);
		send_item(CMD_CLEAR, 0, 0, 0, 0, 1'b0);
		send_item(CMD_READ, 0, 0, 0, 0, 1'b0);
		send_item(CMD_CORNER, 10, 1000, 0, 0, 1'b0);
		send_item(CMD_CORNER, 11, 0, 1000, 0, 1'b1);
	endtask

	task automatic test_negated_output();
		write_negate(1'b1);
		send_triangle(20, 21, 22, '{0, 0, 0, 500, 0, 0, 0, 0, 500});
		send_item(CMD_READ, 21, 0, 0, 0, 1'b0);
		write_negate(1'b0);
	endtask

	function automatic int pick_coord();
		return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535) - 32768
			: $urandom_range(0, 400) - 200;
	endfunction

	function automatic int pick_vertex(int pool);
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
			: $urandom_range(0, pool - 1);
	endfunction

	// random meshes with reads, clears and noise
	task automatic test_random_mesh(int n_items, int pool);
		int sent, r, ncorn, x, y, z;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					ncorn = $urandom_range(1, 2);
				else if (r < 14)
					ncorn = $urandom_range(MAX_CORNERS + 1, MAX_CORNERS + 3);
				else
					ncorn = $urandom_range(3, 8);
				x = pick_coord();
				y = pick_coord();
				z = pick_coord();
				for (int k = 0; k < ncorn; k++) begin
					// occasional read inside the polygon
					if ($urandom_range(0, 19) == 0) begin
						send_item(CMD_READ, pick_vertex(pool), 0, 0, 0, 1'b0);
						sent++;
					end
					// occasional repeated corner
					if ($urandom_range(0, 9) != 0) begin
						x = pick_coord();
						y = pick_coord();
						z = pick_coord();
					end
					send_item(CMD_CORNER, pick_vertex(pool), x, y, z, k == ncorn - 1);
					sent++;
				end
			end else if (r < 90) begin
				send_item(CMD_READ, pick_vertex(pool), pick_coord(), 0, 0,
					$urandom_range(0, 1));
				sent++;
			end else if (r < 92) begin
				send_item(CMD_CLEAR, $urandom_range(0, 1023), 0, 0, 0, 1'b0);
				sent++;
			end else begin
				send_item(CMD_UNUSED, $urandom_range(0, 1023), pick_coord(),
					pick_coord(), pick_coord(), $urandom_range(0, 1));
			end
		end
		// close any open polygon before the register may change
		send_item(CMD_CORNER, 0, 0, 0, 0, 1'b1);
	endtask

	// result side: random stalls and comparison against the oldest expectation
	int stall_left = 0;
	always @(posedge clk) begin
		normal_result_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_normals.size() == 0) begin
					$error("unexpected result transaction");
					failures++;
				end else begin
					e = pending_normals.pop_front();
					n_checked++;
					if (result_kind !== e.kind) begin
						$error("result_kind expected %0d actual %0d", e.kind, result_kind);
						failures++;
					end
					if (normal_x !== e.nx) begin
						$error("normal_x expected %0d actual %0d", e.nx, normal_x);
						failures++;
					end
					if (normal_y !== e.ny) begin
						$error("normal_y expected %0d actual %0d", e.ny, normal_y);
						failures++;
					end
					if (normal_z !== e.nz) begin
						$error("normal_z expected %0d actual %0d", e.nz, normal_z);
						failures++;
					end
					if (degenerate !== e.degen) begin
						$error("degenerate expected %0d actual %0d", e.degen, degenerate);
						failures++;
					end
					if (corner_overflow !== e.ovf) begin
						$error("corner_overflow expected %0d actual %0d", e.ovf,
							corner_overflow);
						failures++;
					end
				end
				stall_left = no_idle ? 0 : $urandom_range(0, 10);
			end
			out_ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// run limit
	initial begin
		#40ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		negate_flag = 1'b0;
		corner_cnt = 0;
		for (int i = 0; i < 3; i++) begin
			first_pt[i] = 0;
			second_pt[i] = 0;
			older_pt[i] = 0;
			newer_pt[i] = 0;
			newell_acc[i] = 0;
		end
		foreach (vert_acc[k, i])
			vert_acc[k][i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		write_negate(1'b0);

		test_unwritten_reads();
		test_short_polygons();
		test_extreme_triangle();
		test_flat_polygon();
		test_unused_and_clear();
		test_negated_output();

		no_idle = 1'b1;
		test_random_mesh(300, 64);
		no_idle = 1'b0;
		write_negate(1'b1);
		test_random_mesh(350, 1024);
		write_negate(1'b0);
		test_random_mesh(380, 4);

		drain_and_settle();
		$display("covered %0d polygons, %0d vertex reads, %0d clears", n_polygons,
			n_reads, n_clears);
		$display("%0d result transactions compared, both negate settings", n_checked);
		if (failures == 0 && pending_normals.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/pvn_pkg.sv
hdl/pvn_ram.sv
hdl/polygon_and_vertex_normals_top.sv
hdl/pvn_checker.sv
tb/tb_polygon_and_vertex_normals_top.sv
